// ===== hw/rtl/assert_macros.svh =====
// Assertion helper macros shared by the RTL that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/tjd_pkg.sv =====
// Types, widths and constants shared by the trajectory jump detector.
`timescale 1ns / 1ps
`default_nettype none

package tjd_pkg;

  localparam int POSITION_BITS = 28;
  localparam int TIME_BITS     = 63;
  localparam int SPEED_BITS    = 24;

  // Magnitude of a position step, and the sum of three squared steps.
  localparam int DIFF_BITS = POSITION_BITS + 1;
  localparam int DIST_BITS = 2 * DIFF_BITS + 2;
  // Speed limit times time step.
  localparam int RATE_BITS = SPEED_BITS + TIME_BITS;

  // Limb arithmetic for the shared multiplier.
  localparam int LIMB_BITS     = 32;
  localparam int LIMB_SHIFT    = $clog2(LIMB_BITS);
  localparam int WIDEST        = (DIST_BITS > RATE_BITS) ? DIST_BITS : RATE_BITS;
  localparam int LIMBS         = (WIDEST + LIMB_BITS - 1) / LIMB_BITS;
  localparam int OPND_BITS     = LIMBS * LIMB_BITS;
  localparam int ACC_BITS      = 2 * OPND_BITS;
  localparam int LIMB_IDX_BITS = (LIMBS > 1) ? $clog2(LIMBS) : 1;
  localparam int SHIFT_BITS    = (LIMBS > 1) ? $clog2(2 * LIMBS - 1) : 1;

  localparam logic [SPEED_BITS-1:0] SPEED_RESET = SPEED_BITS'(50000);
  // Microseconds per second, squared.
  localparam logic [OPND_BITS-1:0]  SCALE       = OPND_BITS'(64'd1000000000000);

  typedef enum logic [2:0] {
    VERDICT_NO_TIME   = 3'd0,
    VERDICT_TIME_BACK = 3'd1,
    VERDICT_NO_POS    = 3'd2,
    VERDICT_WITHIN    = 3'd3,
    VERDICT_OVER      = 3'd4
  } verdict_t;

  typedef struct packed {
    logic [TIME_BITS-1:0]            device_time_us;
    logic [TIME_BITS-1:0]            record_time_us;
    logic                            position_valid;
    logic signed [POSITION_BITS-1:0] north_mm;
    logic signed [POSITION_BITS-1:0] east_mm;
    logic signed [POSITION_BITS-1:0] down_mm;
  } sample_t;

  typedef struct packed {
    logic       likely_jump;
    logic [2:0] verdict_code;
  } result_t;

  // Classified sample handed from the front end to the arithmetic back end.
  typedef struct packed {
    logic                 needs_math;
    verdict_t             verdict_code;
    logic [TIME_BITS-1:0] time_step;
    logic [DIFF_BITS-1:0] north_step;
    logic [DIFF_BITS-1:0] east_step;
    logic [DIFF_BITS-1:0] down_step;
  } job_t;

  typedef struct packed {
    logic start;
    logic clear;
  } mac_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tjd_front.sv =====
// Front end: keeps the previous sample and classifies each new one.
`timescale 1ns / 1ps
`default_nettype none

module tjd_front import tjd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    sample_valid,
  output logic    sample_ready,
  input  sample_t sample,
  output logic    job_valid,
  input  logic    job_ready,
  output job_t    job
);

  logic [TIME_BITS-1:0]            last_device_time;
  logic [TIME_BITS-1:0]            last_record_time;
  logic                            last_position_valid;
  logic signed [POSITION_BITS-1:0] last_north;
  logic signed [POSITION_BITS-1:0] last_east;
  logic signed [POSITION_BITS-1:0] last_down;

  logic                 dev_pair;
  logic                 rec_pair;
  logic [TIME_BITS-1:0] prev_time;
  logic [TIME_BITS-1:0] cur_time;
  logic [TIME_BITS:0]   time_diff;
  logic                 forward;

  function automatic logic [DIFF_BITS-1:0] abs_step(
    input logic signed [POSITION_BITS-1:0] cur,
    input logic signed [POSITION_BITS-1:0] prev
  );
    logic signed [DIFF_BITS-1:0] d;
    d = DIFF_BITS'(cur) - DIFF_BITS'(prev);
    return d[DIFF_BITS-1] ? $unsigned(-d) : $unsigned(d);
  endfunction

  always_comb begin
    dev_pair  = (last_device_time != '0) && (sample.device_time_us != '0);
    rec_pair  = (last_record_time != '0) && (sample.record_time_us != '0);
    prev_time = dev_pair ? last_device_time : last_record_time;
    cur_time  = dev_pair ? sample.device_time_us : sample.record_time_us;
    time_diff = {1'b0, cur_time} - {1'b0, prev_time};
    // A borrow or a zero step both mean the time did not move forward.
    forward   = !time_diff[TIME_BITS] && (time_diff[TIME_BITS-1:0] != '0);

    job.needs_math   = 1'b0;
    job.verdict_code = VERDICT_WITHIN;
    job.time_step    = time_diff[TIME_BITS-1:0];
    job.north_step   = abs_step(sample.north_mm, last_north);
    job.east_step    = abs_step(sample.east_mm, last_east);
    job.down_step    = abs_step(sample.down_mm, last_down);
    if (!(dev_pair || rec_pair)) begin
      job.verdict_code = VERDICT_NO_TIME;
    end else if (!forward) begin
      job.verdict_code = VERDICT_TIME_BACK;
    end else if (!(last_position_valid && sample.position_valid)) begin
      job.verdict_code = VERDICT_NO_POS;
    end else begin
      job.needs_math = 1'b1;
    end
  end

  assign job_valid    = sample_valid;
  assign sample_ready = job_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_device_time    <= '0;
      last_record_time    <= '0;
      last_position_valid <= 1'b0;
      last_north          <= '0;
      last_east           <= '0;
      last_down           <= '0;
    end else if (sample_valid && sample_ready) begin
      last_device_time    <= sample.device_time_us;
      last_record_time    <= sample.record_time_us;
      last_position_valid <= sample.position_valid;
      last_north          <= sample.north_mm;
      last_east           <= sample.east_mm;
      last_down           <= sample.down_mm;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tjd_queue.sv =====
// Small FIFO of classified samples between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module tjd_queue import tjd_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_data
);

  localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_BITS = $clog2(DEPTH + 1);

  job_t                  slots [DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr;
  logic [PTR_BITS-1:0]   rd_ptr;
  logic [COUNT_BITS-1:0] count;
  logic                  push;
  logic                  pop;

  assign push_ready = (count != COUNT_BITS'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tjd_mac.sv =====
// Limb-serial multiply-accumulate unit built on one 32x32 multiplier.
`timescale 1ns / 1ps
`default_nettype none

module tjd_mac import tjd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  mac_cmd_t             cmd,
  input  logic [OPND_BITS-1:0] a,
  input  logic [OPND_BITS-1:0] b,
  output logic                 done,
  output logic [ACC_BITS-1:0]  acc
);

  localparam logic [LIMB_IDX_BITS-1:0] LAST_LIMB = LIMB_IDX_BITS'(LIMBS - 1);

  logic [OPND_BITS-1:0]     a_reg;
  logic [OPND_BITS-1:0]     b_reg;
  logic [LIMB_IDX_BITS-1:0] i_idx;
  logic [LIMB_IDX_BITS-1:0] j_idx;
  logic                     issuing;
  logic                     last_issue;
  logic [2*LIMB_BITS-1:0]   prod;
  logic [SHIFT_BITS-1:0]    prod_shift;
  logic                     prod_valid;
  logic                     prod_last;

  assign last_issue = (i_idx == LAST_LIMB) && (j_idx == LAST_LIMB);

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing    <= 1'b0;
      prod_valid <= 1'b0;
      done       <= 1'b0;
      i_idx      <= '0;
      j_idx      <= '0;
    end else begin
      done       <= prod_valid && prod_last;
      prod_valid <= issuing;
      if (cmd.start) begin
        issuing <= 1'b1;
        i_idx   <= '0;
        j_idx   <= '0;
      end else if (issuing) begin
        if (last_issue) begin
          issuing <= 1'b0;
        end
        if (j_idx == LAST_LIMB) begin
          j_idx <= '0;
          i_idx <= i_idx + 1'b1;
        end else begin
          j_idx <= j_idx + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      a_reg <= a;
      b_reg <= b;
    end
    // One partial product per cycle, added in at its limb offset in the next cycle.
    prod       <= a_reg[i_idx*LIMB_BITS +: LIMB_BITS] * b_reg[j_idx*LIMB_BITS +: LIMB_BITS];
    prod_shift <= SHIFT_BITS'(i_idx) + SHIFT_BITS'(j_idx);
    prod_last  <= last_issue;
    if (cmd.start && cmd.clear) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + (ACC_BITS'(prod) << {prod_shift, LIMB_SHIFT'(0)});
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tjd_back.sv =====
// Back end: runs the exact speed test on the shared multiplier and holds the result.
`timescale 1ns / 1ps
`default_nettype none

module tjd_back import tjd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [SPEED_BITS-1:0] max_speed,
  input  logic                  job_valid,
  output logic                  job_ready,
  input  job_t                  job,
  output logic                  verdict_valid,
  input  logic                  verdict_ready,
  output result_t               verdict
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MATH = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  // Product steps, in the order they run.
  typedef enum logic [2:0] {
    OP_SQ_NORTH    = 3'd0,
    OP_SQ_EAST     = 3'd1,
    OP_SQ_DOWN     = 3'd2,
    OP_SCALE       = 3'd3,
    OP_SPEED_DT    = 3'd4,
    OP_SQUARE_RATE = 3'd5
  } op_t;

  state_t               state;
  op_t                  op;
  op_t                  next_op;
  job_t                 cur;
  logic [ACC_BITS-1:0]  lhs;
  verdict_t             pending;

  mac_cmd_t             cmd;
  logic [OPND_BITS-1:0] mac_a;
  logic [OPND_BITS-1:0] mac_b;
  logic                 mac_done;
  logic [ACC_BITS-1:0]  mac_acc;

  logic out_free;
  logic take_direct;
  logic take_math;
  logic advance;
  logic finish;
  logic emit_now;

  function automatic result_t make_result(input verdict_t code);
    result_t r;
    r.likely_jump  = (code == VERDICT_TIME_BACK) || (code == VERDICT_OVER);
    r.verdict_code = code;
    return r;
  endfunction

  tjd_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .a    (mac_a),
    .b    (mac_b),
    .done (mac_done),
    .acc  (mac_acc)
  );

  always_comb begin
    out_free    = !verdict_valid || verdict_ready;
    take_direct = (state == ST_IDLE) && job_valid && !job.needs_math && out_free;
    take_math   = (state == ST_IDLE) && job_valid && job.needs_math;
    job_ready   = take_direct || take_math;
    advance     = (state == ST_MATH) && mac_done && (op != OP_SQUARE_RATE);
    finish      = (state == ST_MATH) && mac_done && (op == OP_SQUARE_RATE);
    emit_now    = (state == ST_EMIT) && out_free;
    next_op     = take_math ? OP_SQ_NORTH : op_t'(op + 3'd1);
    cmd.start   = take_math || advance;
    // The three squared steps share one running sum.
    cmd.clear   = (next_op != OP_SQ_EAST) && (next_op != OP_SQ_DOWN);

    unique case (next_op)
      OP_SQ_NORTH: begin
        mac_a = OPND_BITS'(job.north_step);
        mac_b = OPND_BITS'(job.north_step);
      end
      OP_SQ_EAST: begin
        mac_a = OPND_BITS'(cur.east_step);
        mac_b = OPND_BITS'(cur.east_step);
      end
      OP_SQ_DOWN: begin
        mac_a = OPND_BITS'(cur.down_step);
        mac_b = OPND_BITS'(cur.down_step);
      end
      OP_SCALE: begin
        mac_a = mac_acc[OPND_BITS-1:0];
        mac_b = SCALE;
      end
      OP_SPEED_DT: begin
        mac_a = OPND_BITS'(max_speed);
        mac_b = OPND_BITS'(cur.time_step);
      end
      OP_SQUARE_RATE: begin
        mac_a = mac_acc[OPND_BITS-1:0];
        mac_b = mac_acc[OPND_BITS-1:0];
      end
      default: begin
        mac_a = '0;
        mac_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      op            <= OP_SQ_NORTH;
      verdict_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (take_math) begin
            state <= ST_MATH;
          end
        end
        ST_MATH: begin
          if (finish) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_now) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (cmd.start) begin
        op <= next_op;
      end
      if (take_direct || emit_now) begin
        verdict_valid <= 1'b1;
      end else if (verdict_ready) begin
        verdict_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_math) begin
      cur <= job;
    end
    if ((state == ST_MATH) && mac_done && (op == OP_SCALE)) begin
      lhs <= mac_acc;
    end
    if (finish) begin
      pending <= (lhs > mac_acc) ? VERDICT_OVER : VERDICT_WITHIN;
    end
    if (take_direct) begin
      verdict <= make_result(job.verdict_code);
    end else if (emit_now) begin
      verdict <= make_result(pending);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/trajectory_jump_detector.sv =====
// Top level of the trajectory jump detector: front end, job queue, back end.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Usage:
// Samples enter on the sample channel (sample_valid / sample_ready / sample) and one
// verdict per sample leaves on the verdict channel (verdict_valid / verdict_ready /
// verdict), in the same order. The speed limit register is written through cfg_we
// and cfg_wdata; the user must write it only while no sample is in flight, as the
// block itself does not enforce this.
// The front end compares each sample with the previous one and drops a classified
// job into a queue of QUEUE_DEPTH entries. A sample whose verdict follows from its
// times or position flags alone goes from the queue into the back end's output
// register, and such samples can follow one per cycle while the back end is idle
// and the receiver takes each verdict. A sample that needs the speed test runs six
// wide products on one shared 32x32 multiplier, nine limb products each, and the
// back end takes no new sample before its verdict is in the output register.
// The verdict sits in an output register, so while the receiver stalls the back end
// finishes its current sample and the front end keeps filling the queue; the sample
// channel only drops ready when the queue is full.
// Reset clears the stored previous sample (so the first verdict reports no time
// pair), empties the queue and the output register, and sets the speed limit to
// 50000 mm/s.

module trajectory_jump_detector import tjd_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [SPEED_BITS-1:0] cfg_wdata,
  input  logic                  sample_valid,
  output logic                  sample_ready,
  input  sample_t               sample,
  output logic                  verdict_valid,
  input  logic                  verdict_ready,
  output result_t               verdict
);

  // Speed limit in mm/s; the back end reads it live while a test runs.
  logic [SPEED_BITS-1:0] max_speed;

  // Front end to queue.
  logic front_valid;
  logic front_ready;
  job_t front_job;

  // Queue head to back end.
  logic job_valid;
  logic job_ready;
  job_t job;

  // Terms used by the checks below.
  logic sample_xfer;
  logic code_ok;
  logic jump_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed <= SPEED_RESET;
    end else if (cfg_we) begin
      max_speed <= cfg_wdata;
    end
  end

  tjd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .job_valid    (front_valid),
    .job_ready    (front_ready),
    .job          (front_job)
  );

  tjd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  (front_job),
    .pop_valid  (job_valid),
    .pop_ready  (job_ready),
    .pop_data   (job)
  );

  tjd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .max_speed     (max_speed),
    .job_valid     (job_valid),
    .job_ready     (job_ready),
    .job           (job),
    .verdict_valid (verdict_valid),
    .verdict_ready (verdict_ready),
    .verdict       (verdict)
  );

  assign sample_xfer = sample_valid && sample_ready;
  assign code_ok     = (verdict.verdict_code <= VERDICT_OVER);
  assign jump_ok     = (verdict.likely_jump == ((verdict.verdict_code == VERDICT_TIME_BACK) ||
                                                (verdict.verdict_code == VERDICT_OVER)));

  // A transferred sample must be waiting in the queue on the next cycle.
  `ASSERT_NEXT(a_sample_queued, clk, rst, sample_xfer, job_valid, "sample transfer not queued")

  // Only the five defined verdict codes may leave the block.
  `ASSERT_HOLDS(a_code_range, clk, rst, !verdict_valid || code_ok, "verdict code out of range")

  // The jump flag is set exactly for time going backward or an over-limit speed.
  `ASSERT_HOLDS(a_jump_flag, clk, rst, !verdict_valid || jump_ok, "jump flag disagrees with code")

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the trajectory jump detector.
`timescale 1ns / 1ps

module testbench import tjd_pkg::*;;

  localparam int unsigned SPEED_MAX   = (1 << SPEED_BITS) - 1;
  localparam longint      CYCLE_LIMIT = 2000000;
  localparam int          PHASE_ITEMS = 230;
  // Cycles to let pass after the last verdict.
  localparam int          SETTLE      = 100;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    cfg_we = 1'b0;
  logic [SPEED_BITS-1:0] cfg_wdata = '0;
  logic    sample_valid = 1'b0;
  logic    sample_ready;
  sample_t sample = '0;
  logic    verdict_valid;
  logic    verdict_ready = 1'b0;
  result_t verdict;

  trajectory_jump_detector dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .verdict_valid(verdict_valid),
    .verdict_ready(verdict_ready),
    .verdict      (verdict)
  );

  // 12 ns period: six high, six low.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // The tracker mirrors the detector: it keeps its own copy of the previous
  // sample and the speed limit, predicts the verdict of every sample transfer
  // and compares the verdict transfers against those predictions in order.
  class jump_tracker;
    sample_t               prev;
    logic [SPEED_BITS-1:0] speed_limit;
    result_t               pending_verdicts[$];
    int                    errors;
    int                    checked;

    function new();
      prev        = '0;
      speed_limit = SPEED_RESET;
      errors      = 0;
      checked     = 0;
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // Absolute step along one axis, with both ends taken as two's complement.
    function longint axis_gap(logic signed [POSITION_BITS-1:0] now_mm,
                              logic signed [POSITION_BITS-1:0] was_mm);
      longint gap;
      gap = longint'(now_mm) - longint'(was_mm);
      return (gap < 0) ? -gap : gap;
    endfunction

    // Judges one sample against the stored one. The speed test is the exact
    // form dist^2 * 10^12 > (limit * dt)^2; 256 bits hold either side whole.
    function verdict_t classify(sample_t s);
      logic [TIME_BITS-1:0] t_was, t_now, t_step;
      logic [255:0]         dist2, lhs, rhs;
      longint               dn, de, dd;
      if (prev.device_time_us != '0 && s.device_time_us != '0) begin
        t_was = prev.device_time_us;
        t_now = s.device_time_us;
      end else if (prev.record_time_us != '0 && s.record_time_us != '0) begin
        t_was = prev.record_time_us;
        t_now = s.record_time_us;
      end else begin
        return VERDICT_NO_TIME;
      end
      if (t_now <= t_was) return VERDICT_TIME_BACK;
      if (!prev.position_valid || !s.position_valid) return VERDICT_NO_POS;
      t_step = t_now - t_was;
      dn = axis_gap(s.north_mm, prev.north_mm);
      de = axis_gap(s.east_mm, prev.east_mm);
      dd = axis_gap(s.down_mm, prev.down_mm);
      dist2 = 256'(dn) * 256'(dn) + 256'(de) * 256'(de) + 256'(dd) * 256'(dd);
      lhs   = dist2 * 256'(64'd1000000000000);
      rhs   = 256'(speed_limit) * 256'(t_step);
      rhs   = rhs * rhs;
      return (lhs > rhs) ? VERDICT_OVER : VERDICT_WITHIN;
    endfunction

    // Called for every sample transfer; the stored sample is always replaced.
    function void note_sample(sample_t s);
      verdict_t v;
      result_t  r;
      v = classify(s);
      r.verdict_code = v;
      r.likely_jump  = (v == VERDICT_TIME_BACK || v == VERDICT_OVER);
      pending_verdicts.push_back(r);
      prev = s;
    endfunction

    task check_verdict(result_t got);
      result_t want;
      checked++;
      if (pending_verdicts.size() == 0) begin
        report_mismatch($sformatf("verdict %0d arrived with none pending", checked));
      end else begin
        want = pending_verdicts.pop_front();
        if (got.likely_jump !== want.likely_jump)
          report_mismatch($sformatf("verdict %0d: likely_jump %b, expected %b",
                                    checked, got.likely_jump, want.likely_jump));
        if (got.verdict_code !== want.verdict_code)
          report_mismatch($sformatf("verdict %0d: verdict_code %0d, expected %0d",
                                    checked, got.verdict_code, want.verdict_code));
      end
    endtask
  endclass

  jump_tracker tracker = new();

  // Idle rates in percent, changed from phase to phase.
  int unsigned sender_idle_pct = 0;
  int unsigned stall_pct       = 0;
  longint      cycle_count     = 0;

  // Random walk that the well-formed random samples follow.
  logic [TIME_BITS-1:0]            gen_dev = 63'd1000;
  logic [TIME_BITS-1:0]            gen_rec = 63'd5000;
  logic signed [POSITION_BITS-1:0] gen_n = '0;
  logic signed [POSITION_BITS-1:0] gen_e = '0;
  logic signed [POSITION_BITS-1:0] gen_d = '0;

  // The receiver decides at each falling edge whether to take a verdict.
  always @(negedge clk) begin
    verdict_ready = rst ? 1'b0 : ($urandom_range(0, 99) >= stall_pct);
  end

  // Every verdict transfer is checked at the rising edge where it happens.
  always @(posedge clk) begin
    if (!rst && verdict_valid && verdict_ready) tracker.check_verdict(verdict);
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic sample_t make_sample(logic [TIME_BITS-1:0] dev,
                                          logic [TIME_BITS-1:0] rec,
                                          logic valid, int n, int e, int d);
    sample_t s;
    s.device_time_us = dev;
    s.record_time_us = rec;
    s.position_valid = valid;
    s.north_mm       = POSITION_BITS'(n);
    s.east_mm        = POSITION_BITS'(e);
    s.down_mm        = POSITION_BITS'(d);
    return s;
  endfunction

  function automatic logic [TIME_BITS-1:0] random_time();
    return TIME_BITS'({$urandom, $urandom});
  endfunction

  // Moves one coordinate by up to reach+1 millimetres either way, so that
  // the step straddles the speed limit.
  function automatic logic signed [POSITION_BITS-1:0] drift(
      logic signed [POSITION_BITS-1:0] at, longint reach);
    longint off;
    off = longint'($urandom_range(0, int'(2 * reach + 2))) - (reach + 1);
    return POSITION_BITS'(longint'(at) + off);
  endfunction

  function automatic void wander(longint reach);
    gen_n = drift(gen_n, reach);
    gen_e = drift(gen_e, reach);
    gen_d = drift(gen_d, reach);
  endfunction

  // Most random samples continue a plausible track with a random time step
  // and a displacement near the limit; the rest drop a clock, run time
  // backward, lose the position, lose both clocks, or are plain noise.
  function automatic sample_t random_sample();
    int unsigned          kind;
    longint               step_us, reach;
    logic [TIME_BITS-1:0] dev_out, rec_out;
    logic                 valid_out;
    kind      = $urandom_range(0, 99);
    step_us   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 50)
                                            : $urandom_range(1, 2000000);
    reach     = longint'(tracker.speed_limit) * step_us / 1000000;
    valid_out = 1'b1;
    if (kind < 60) begin
      gen_dev += TIME_BITS'(step_us);
      gen_rec += TIME_BITS'(step_us + $urandom_range(0, 5));
      dev_out = gen_dev;
      rec_out = gen_rec;
      wander(reach);
    end else if (kind < 70) begin
      // Device clock missing, so the record pair decides this and the next.
      gen_rec += TIME_BITS'(step_us);
      dev_out = '0;
      rec_out = gen_rec;
      wander(reach);
    end else if (kind < 75) begin
      dev_out = gen_dev - TIME_BITS'($urandom_range(0, 3));
      rec_out = gen_rec - TIME_BITS'($urandom_range(0, 3));
    end else if (kind < 85) begin
      gen_dev += TIME_BITS'(step_us);
      gen_rec += TIME_BITS'(step_us);
      dev_out   = gen_dev;
      rec_out   = gen_rec;
      valid_out = 1'b0;
      wander(reach);
    end else if (kind < 90) begin
      dev_out = '0;
      rec_out = '0;
      wander(reach);
    end else begin
      dev_out   = random_time();
      rec_out   = random_time();
      valid_out = 1'($urandom_range(0, 1));
      gen_n     = POSITION_BITS'($urandom);
      gen_e     = POSITION_BITS'($urandom);
      gen_d     = POSITION_BITS'($urandom);
      gen_dev   = dev_out;
      gen_rec   = rec_out;
    end
    return make_sample(dev_out, rec_out, valid_out, gen_n, gen_e, gen_d);
  endfunction

  // Entered and left at a falling edge. Valid is only lowered for an idle
  // gap, so back-to-back samples keep it high across the transfer.
  task automatic send_sample(sample_t s);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      sample_valid = 1'b0;
      @(negedge clk);
    end
    sample_valid = 1'b1;
    sample       = s;
    do @(posedge clk); while (!sample_ready);
    tracker.note_sample(s);
    @(negedge clk);
  endtask

  // Holds the sender off until every predicted verdict has been seen.
  task automatic wait_drained();
    sample_valid = 1'b0;
    while (tracker.pending_verdicts.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Only called with nothing in flight.
  task automatic write_speed_limit(logic [SPEED_BITS-1:0] limit);
    cfg_we    = 1'b1;
    cfg_wdata = limit;
    @(negedge clk);
    cfg_we = 1'b0;
    tracker.speed_limit = limit;
  endtask

  initial begin
    localparam logic [TIME_BITS-1:0] T_MAX = {TIME_BITS{1'b1}};
    localparam int P_MAX = (1 << (POSITION_BITS - 1)) - 1;
    localparam int P_MIN = -(1 << (POSITION_BITS - 1));
    int unsigned phase_speed[8] = '{50000, SPEED_MAX, 1, 0, 50000, 1000, 0, 7};
    int unsigned limit;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed samples at the reset speed limit of 50000 mm/s. The first one
    // has no stored times, so no time pair exists.
    send_sample(make_sample(63'd1000, 63'd0, 1'b1, 0, 0, 0));
    // One second and exactly 50000 mm: on the limit, which is not a jump.
    send_sample(make_sample(63'd1001000, 63'd0, 1'b1, 50000, 0, 0));
    // One millimetre more than the limit allows.
    send_sample(make_sample(63'd2001000, 63'd0, 1'b1, 100001, 0, 0));
    // Repeated and then earlier device time.
    send_sample(make_sample(63'd2001000, 63'd0, 1'b1, 100001, 0, 0));
    send_sample(make_sample(63'd500, 63'd0, 1'b1, 100001, 0, 0));
    // Device time absent, no record time stored yet.
    send_sample(make_sample(63'd0, 63'd10, 1'b1, 7, -7, 3));
    // Record pair in use, no movement.
    send_sample(make_sample(63'd0, 63'd20, 1'b1, 7, -7, 3));
    // Position missing in the new sample, then in the stored one.
    send_sample(make_sample(63'd0, 63'd30, 1'b0, -99, 99, 5));
    send_sample(make_sample(63'd0, 63'd40, 1'b1, 7, -7, 3));
    // Neither clock present.
    send_sample(make_sample(63'd0, 63'd0, 1'b1, 7, -7, 3));
    // Extremes of time and position.
    send_sample(make_sample(63'd1, 63'd1, 1'b1, P_MAX, P_MAX, P_MAX));
    send_sample(make_sample(T_MAX, 63'd2, 1'b1, P_MIN, P_MIN, P_MIN));
    send_sample(make_sample(63'd0, 63'd3, 1'b1, P_MAX, P_MAX, P_MAX));
    send_sample(make_sample(63'd5, 63'd0, 1'b1, P_MAX, P_MAX, P_MAX));
    send_sample(make_sample(63'd6, 63'd0, 1'b1, P_MIN, P_MIN, P_MIN));
    send_sample(make_sample(T_MAX, T_MAX, 1'b1, P_MAX, P_MAX, P_MAX));
    wait_drained();

    // A zero limit passes only a sample that has not moved.
    write_speed_limit('0);
    send_sample(make_sample(63'd100, 63'd100, 1'b1, 0, 0, 0));
    send_sample(make_sample(63'd200, 63'd200, 1'b1, 0, 0, 0));
    send_sample(make_sample(63'd300, 63'd300, 1'b1, 1, 0, 0));
    wait_drained();

    // Largest limit: exactly on it, just over it, then the widest step.
    write_speed_limit(SPEED_BITS'(SPEED_MAX));
    send_sample(make_sample(63'd1000300, 63'd0, 1'b1, 16777216, 0, 0));
    send_sample(make_sample(63'd2000300, 63'd0, 1'b1, 33554433, 0, 0));
    send_sample(make_sample(T_MAX, 63'd0, 1'b1, P_MIN, P_MAX, P_MIN));
    wait_drained();

    // Random phases. Each one sets a new speed limit and cycles through the
    // idle patterns: none, sender mostly idle, receiver mostly stalled, and
    // both lightly idle.
    for (int p = 0; p < 8; p++) begin
      limit = (p == 3 || p == 7) ? $urandom_range(0, SPEED_MAX) : phase_speed[p];
      write_speed_limit(SPEED_BITS'(limit));
      case (p % 4)
        0: begin sender_idle_pct = 0;  stall_pct = 0;  end
        1: begin sender_idle_pct = 80; stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  stall_pct = 80; end
        default: begin sender_idle_pct = 10; stall_pct = 10; end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Now and then the sender waits for the pipeline to run dry.
        if (i == 50 || $urandom_range(0, 199) == 0) wait_drained();
        send_sample(random_sample());
      end
      wait_drained();
    end

    sender_idle_pct = 0;
    stall_pct       = 0;
    wait_drained();
    repeat (SETTLE) @(negedge clk);
    if (tracker.errors == 0 && tracker.pending_verdicts.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
